// ===== rtl/stc_pkg.sv =====
// Shared types and constants for the scrolling text console.
`timescale 1ns / 1ps
`default_nettype none

package stc_pkg;

    // Command codes on the input channel.
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Character codes with a meaning of their own.
    localparam logic [7:0] CODE_CR    = 8'd13;
    localparam logic [7:0] CODE_LF    = 8'd10;
    localparam logic [7:0] CODE_SPACE = 8'h20;

    // Field widths of the channel words.
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 3;
    localparam int COL_W  = 5;

    // Operation kinds that the front hands to the back.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUT,
        OP_NEWLINE,
        OP_READ,
        OP_CLEAR
    } op_kind_t;

    // One classified operation in the queue.
    typedef struct packed {
        op_kind_t           kind;
        logic [CHAR_W-1:0]  char_code;
        logic [ROW_W-1:0]   read_row;
        logic [COL_W-1:0]   read_col;
    } op_t;

    // One result word.
    typedef struct packed {
        logic [CHAR_W-1:0]  read_data;
        logic               drawn;
        logic [ROW_W-1:0]   drawn_row;
        logic [COL_W-1:0]   drawn_col;
        logic               scrolled;
        logic [ROW_W-1:0]   cursor_row;
        logic [COL_W-1:0]   cursor_col;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/stc_if.sv =====
// Channel interfaces for the console command and response words.
`timescale 1ns / 1ps
`default_nettype none

interface stc_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] char_code;
    logic [2:0] read_row;
    logic [4:0] read_col;

    modport source (output valid, output command, output char_code,
                    output read_row, output read_col, input ready);
    modport sink   (input valid, input command, input char_code,
                    input read_row, input read_col, output ready);
endinterface

interface stc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       drawn;
    logic [2:0] drawn_row;
    logic [4:0] drawn_col;
    logic       scrolled;
    logic [2:0] cursor_row;
    logic [4:0] cursor_col;

    modport source (output valid, output read_data, output drawn, output drawn_row,
                    output drawn_col, output scrolled, output cursor_row,
                    output cursor_col, input ready);
    modport sink   (input valid, input read_data, input drawn, input drawn_row,
                    input drawn_col, input scrolled, input cursor_row,
                    input cursor_col, output ready);
endinterface

`default_nettype wire

// ===== rtl/scrolling_text_console_unit.sv =====
// Top level of the scrolling text console.
`timescale 1ns / 1ps
`default_nettype none

// A ROWS by COLS character console with a cursor. Command words enter a
// two-entry queue and are carried out one at a time by the back end, which
// owns the character memory with one write and one registered read port.
// A read waits for the registered memory read before its result is ready,
// and the back end starts the next word only once the previous result has
// left the output register, so it never takes a new word before the last
// one is through. Scrolling moves no stored text: rows are addressed through
// a rotating base, and a per-row fill count makes unwritten cells read as
// spaces, so reset and the clear command also take effect at once, with no
// clearing pass.
module scrolling_text_console_unit #(
    parameter int ROWS = 8,
    parameter int COLS = 21
) (
    input  wire logic clk,
    input  wire logic rst_n,
    stc_cmd_if.sink   cmd_ch,
    stc_rsp_if.source rsp_ch
);
    import stc_pkg::*;

    op_t     op;
    logic    op_valid;
    logic    op_ready;
    result_t res;

    stc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_ch   (cmd_ch),
        .op       (op),
        .op_valid (op_valid),
        .op_ready (op_ready)
    );

    stc_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .res       (res),
        .res_valid (rsp_ch.valid),
        .res_ready (rsp_ch.ready)
    );

    // Response word fields.
    assign rsp_ch.read_data  = res.read_data;
    assign rsp_ch.drawn      = res.drawn;
    assign rsp_ch.drawn_row  = res.drawn_row;
    assign rsp_ch.drawn_col  = res.drawn_col;
    assign rsp_ch.scrolled   = res.scrolled;
    assign rsp_ch.cursor_row = res.cursor_row;
    assign rsp_ch.cursor_col = res.cursor_col;

endmodule

`default_nettype wire

// ===== rtl/stc_front.sv =====
// Front end: classifies command words and holds them in a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none

module stc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    stc_cmd_if.sink            cmd_ch,
    output stc_pkg::op_t       op,
    output logic               op_valid,
    input  wire logic          op_ready
);
    import stc_pkg::*;

    op_t        q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    op_t        op_new;
    logic       push, pop;

    // Sort each word into the operation the back has to carry out.
    always_comb
    begin
        op_new.char_code = cmd_ch.char_code;
        op_new.read_row  = cmd_ch.read_row;
        op_new.read_col  = cmd_ch.read_col;
        unique case (cmd_ch.command)
            CMD_PUT:
            begin
                if (cmd_ch.char_code == CODE_LF)
                    op_new.kind = OP_NEWLINE;
                else if (cmd_ch.char_code == CODE_CR)
                    op_new.kind = OP_NOP;
                else
                    op_new.kind = OP_PUT;
            end
            CMD_READ:  op_new.kind = OP_READ;
            CMD_CLEAR: op_new.kind = OP_CLEAR;
            default:   op_new.kind = OP_NOP;
        endcase
    end

    // Queue control.
    assign cmd_ch.ready = (count_reg != 2'd2);
    assign push         = cmd_ch.valid && cmd_ch.ready;
    assign op_valid     = (count_reg != 2'd0);
    assign pop          = op_valid && op_ready;
    assign op           = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= op_new;
    end

endmodule

`default_nettype wire

// ===== rtl/stc_back.sv =====
// Back end: character memory, cursor, scroll bookkeeping and the result register.
`timescale 1ns / 1ps
`default_nettype none

module stc_back #(
    parameter int ROWS = 8,
    parameter int COLS = 21
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire stc_pkg::op_t  op,
    input  wire logic          op_valid,
    output logic               op_ready,
    output stc_pkg::result_t   res,
    output logic               res_valid,
    input  wire logic          res_ready
);
    import stc_pkg::*;

    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int CW1   = $clog2(COLS + 1);
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (1 << CW);

    localparam logic [RW-1:0]  LAST_ROW = RW'(ROWS - 1);
    localparam logic [RW:0]    ROWS_W   = (RW + 1)'(ROWS);
    localparam logic [CW1-1:0] COLS_W   = CW1'(COLS);

    // Character memory: physical row in the high bits, column in the low bits.
    logic [CHAR_W-1:0] mem [DEPTH];
    // Number of written cells at the start of each physical row.
    logic [CW1-1:0]    fill_reg [ROWS];

    logic [RW-1:0]     cur_row_reg, cur_row_next;
    logic [CW-1:0]     cur_col_reg, cur_col_next;
    logic [RW-1:0]     cur_phys_reg, cur_phys_next;
    logic [RW-1:0]     base_reg, base_next;
    logic              rd_pend_reg;
    logic              rd_space_reg;
    logic [CHAR_W-1:0] rd_data_reg;
    result_t           res_reg, res_next;
    logic              res_valid_reg;

    logic              take;
    logic [CW1-1:0]    col_inc;
    logic              wrap;
    logic              newline;
    logic              last_row;
    logic              scroll;
    logic              do_write;
    logic [RW-1:0]     cur_phys_inc;
    logic              rd_in_range;
    logic [RW:0]       rd_sum;
    logic [RW-1:0]     rd_phys;
    logic [CW-1:0]     rd_col;

    assign take      = op_valid && !res_valid_reg && !rd_pend_reg;
    assign op_ready  = take;
    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    // Cursor movement for put and new line.
    assign col_inc      = CW1'(cur_col_reg) + CW1'(1);
    assign wrap         = (col_inc >= COLS_W);
    assign do_write     = (op.kind == OP_PUT);
    assign newline      = (op.kind == OP_NEWLINE) || (do_write && wrap);
    assign last_row     = (cur_row_reg == LAST_ROW);
    assign scroll       = newline && last_row;
    assign cur_phys_inc = (cur_phys_reg == LAST_ROW) ? '0 : cur_phys_reg + RW'(1);

    always_comb
    begin
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        cur_phys_next = cur_phys_reg;
        base_next     = base_reg;
        if (op.kind == OP_CLEAR)
        begin
            cur_row_next  = '0;
            cur_col_next  = '0;
            cur_phys_next = '0;
            base_next     = '0;
        end
        else if (newline)
        begin
            cur_col_next = '0;
            if (last_row)
            begin
                // The oldest row becomes the new bottom row.
                cur_phys_next = base_reg;
                base_next     = (base_reg == LAST_ROW) ? '0 : base_reg + RW'(1);
            end
            else
            begin
                cur_row_next  = cur_row_reg + RW'(1);
                cur_phys_next = cur_phys_inc;
            end
        end
        else if (do_write)
        begin
            cur_col_next = col_inc[CW-1:0];
        end
    end

    // Read address: logical row rotated by the scroll base.
    assign rd_in_range = (32'(op.read_row) < 32'(ROWS)) && (32'(op.read_col) < 32'(COLS));
    assign rd_sum      = (RW + 1)'(base_reg) + (RW + 1)'(op.read_row);
    assign rd_phys     = (rd_sum >= ROWS_W) ? RW'(rd_sum - ROWS_W) : RW'(rd_sum);
    assign rd_col      = CW'(op.read_col);

    // Result word; for a read, the data field is filled in the cycle after it is taken.
    always_comb
    begin
        res_next            = '0;
        res_next.drawn      = do_write;
        res_next.drawn_row  = do_write ? ROW_W'(cur_row_reg) : '0;
        res_next.drawn_col  = do_write ? COL_W'(cur_col_reg) : '0;
        res_next.scrolled   = scroll && (op.kind != OP_CLEAR);
        res_next.cursor_row = ROW_W'(cur_row_next);
        res_next.cursor_col = COL_W'(cur_col_next);
    end

    // Memory port: at most one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (take && do_write)
            mem[AW'({cur_phys_reg, cur_col_reg})] <= op.char_code;
        rd_data_reg <= mem[AW'({rd_phys, rd_col})];
    end

    // Row fill counts; a cell at or past the count reads as a space.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
                fill_reg[r] <= '0;
        end
        else if (take)
        begin
            if (op.kind == OP_CLEAR)
            begin
                for (int r = 0; r < ROWS; r++)
                    fill_reg[r] <= '0;
            end
            else
            begin
                if (do_write)
                    fill_reg[cur_phys_reg] <= col_inc;
                if (scroll)
                    fill_reg[base_reg] <= '0;
            end
        end
    end

    // Cursor, scroll base and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            cur_phys_reg  <= '0;
            base_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
                res_valid_reg <= 1'b0;
            if (take)
            begin
                cur_row_reg  <= cur_row_next;
                cur_col_reg  <= cur_col_next;
                cur_phys_reg <= cur_phys_next;
                base_reg     <= base_next;
                if (op.kind == OP_READ)
                    rd_pend_reg <= 1'b1;
                else
                    res_valid_reg <= 1'b1;
            end
            else if (rd_pend_reg)
            begin
                rd_pend_reg   <= 1'b0;
                res_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg      <= res_next;
            rd_space_reg <= !rd_in_range || (CW1'(rd_col) >= fill_reg[rd_phys]);
        end
        else if (rd_pend_reg)
        begin
            res_reg.read_data <= rd_space_reg ? CODE_SPACE : rd_data_reg;
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_scrolling_text_console_unit.sv =====
// Testbench for the scrolling text console: table-driven and random command words checked against a predictor.
`timescale 1ns / 1ps

module tb_scrolling_text_console_unit;
    import stc_pkg::*;

    localparam int ROWS = 8;
    localparam int COLS = 21;
    localparam int RANDOM_WORDS = 1000;
    localparam int BACKLOG_CYCLES = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    // The command code that the console must ignore.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One directed word, with its expected result where it is typed in.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] code;
        logic [2:0] row;
        logic [4:0] col;
        bit         typed;
        result_t    want;
    } script_row_t;

    // What the sender knows about a word it offers.
    typedef struct packed {
        bit      typed;
        result_t want;
    } offer_note_t;

    logic clk = 1'b0;
    logic rst_n;

    stc_cmd_if cmd_ch ();
    stc_rsp_if rsp_ch ();

    scrolling_text_console_unit #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_ch(cmd_ch),
        .rsp_ch(rsp_ch)
    );

    always #5 clk = ~clk;

    // Predicted console contents and cursor.
    logic [7:0] screen [ROWS][COLS];
    int unsigned cur_row;
    int unsigned cur_col;

    offer_note_t offer_notes [$];
    result_t     pending_results [$];
    script_row_t script [26];

    int  fault_count = 0;
    bit  steady = 1'b0;
    bit  hold_request = 1'b0;

    function automatic void wipe_screen();
        int r;
        int c;
        for (r = 0; r < ROWS; r++)
        begin
            for (c = 0; c < COLS; c++)
            begin
                screen[r][c] = CODE_SPACE;
            end
        end
        cur_row = 0;
        cur_col = 0;
    endfunction

    // Moves the cursor to the next row; on the last row the text scrolls up.
    function automatic bit start_new_line();
        int r;
        int c;
        cur_col = 0;
        if (cur_row + 1 < ROWS)
        begin
            cur_row++;
            return 1'b0;
        end
        for (r = 0; r + 1 < ROWS; r++)
        begin
            screen[r] = screen[r + 1];
        end
        for (c = 0; c < COLS; c++)
        begin
            screen[ROWS - 1][c] = CODE_SPACE;
        end
        cur_row = ROWS - 1;
        return 1'b1;
    endfunction

    // Applies one command word to the predicted console and returns its result.
    function automatic result_t console_step(logic [1:0] op, logic [7:0] code,
                                             logic [2:0] row, logic [4:0] col);
        result_t res;
        res = '0;
        case (op)
            CMD_PUT:
            begin
                if (code == CODE_LF)
                begin
                    res.scrolled = start_new_line();
                end
                else if (code != CODE_CR)
                begin
                    screen[cur_row][cur_col] = code;
                    res.drawn = 1'b1;
                    res.drawn_row = ROW_W'(cur_row);
                    res.drawn_col = COL_W'(cur_col);
                    cur_col++;
                    if (cur_col >= COLS)
                    begin
                        res.scrolled = start_new_line();
                    end
                end
            end
            CMD_READ:
            begin
                if (row < ROWS && col < COLS)
                begin
                    res.read_data = screen[row][col];
                end
                else
                begin
                    res.read_data = CODE_SPACE;
                end
            end
            CMD_CLEAR:
            begin
                wipe_screen();
            end
            default:
            begin
            end
        endcase
        res.cursor_row = ROW_W'(cur_row);
        res.cursor_col = COL_W'(cur_col);
        return res;
    endfunction

    function automatic result_t want_word(int data, int drawn, int drow, int dcol,
                                          int scrolled, int crow, int ccol);
        result_t res;
        res.read_data = CHAR_W'(data);
        res.drawn = 1'(drawn);
        res.drawn_row = ROW_W'(drow);
        res.drawn_col = COL_W'(dcol);
        res.scrolled = 1'(scrolled);
        res.cursor_row = ROW_W'(crow);
        res.cursor_col = COL_W'(ccol);
        return res;
    endfunction

    // Offers one word, with random gaps, and returns at the edge that takes it.
    task automatic send_word(input logic [1:0] op, input logic [7:0] code,
                             input logic [2:0] row, input logic [4:0] col,
                             input bit typed, input result_t want);
        while (!steady && $urandom_range(0, 99) < 36)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        offer_notes.push_back('{typed, want});
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= op;
        cmd_ch.char_code <= code;
        cmd_ch.read_row <= row;
        cmd_ch.read_col <= col;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Check each result word against the oldest expectation, then record new ones.
    always @(posedge clk)
    begin
        result_t     seen;
        result_t     want;
        offer_note_t note;
        result_t     predicted;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                seen = '{rsp_ch.read_data, rsp_ch.drawn, rsp_ch.drawn_row, rsp_ch.drawn_col,
                         rsp_ch.scrolled, rsp_ch.cursor_row, rsp_ch.cursor_col};
                if (pending_results.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: result word with nothing expected", $realtime);
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    // Every field is compared, so any differing bit is a mismatch.
                    if (seen !== want)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: mismatch, expected data=%h drawn=%b at %0d,%0d",
                                     $realtime, want.read_data, want.drawn, want.drawn_row,
                                     want.drawn_col,
                                     " scrolled=%b cursor=%0d,%0d; got data=%h drawn=%b",
                                     want.scrolled, want.cursor_row, want.cursor_col,
                                     seen.read_data, seen.drawn,
                                     " at %0d,%0d scrolled=%b cursor=%0d,%0d",
                                     seen.drawn_row, seen.drawn_col, seen.scrolled,
                                     seen.cursor_row, seen.cursor_col);
                        end
                    end
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                predicted = console_step(cmd_ch.command, cmd_ch.char_code,
                                         cmd_ch.read_row, cmd_ch.read_col);
                note = offer_notes.pop_front();
                pending_results.push_back(note.typed ? note.want : predicted);
            end
        end
    end

    // Result sink: random stalls, plus one long hold that backs up the input.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                repeat (BACKLOG_CYCLES)
                begin
                    rsp_ch.ready <= 1'b0;
                    @(posedge clk);
                end
                hold_request = 1'b0;
            end
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 36);
        end
    end

    // Overall time limit.
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Reset, directed words, random words, then drain.
    initial
    begin
        int         i;
        int         useful;
        int         pick;
        int         kind;
        logic [1:0] op;
        logic [7:0] code;
        logic [2:0] row;
        logic [4:0] col;

        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = CMD_PUT;
        cmd_ch.char_code = 8'h00;
        cmd_ch.read_row = 3'd0;
        cmd_ch.read_col = 5'd0;
        wipe_screen();

        // Cells read as spaces after reset; then extremes, ignored words,
        // a clear, and a walk down to the last row that ends in a scroll.
        script = '{
            '{CMD_READ,   8'h00,   3'd0, 5'd0,  1'b1, want_word(8'h20, 0, 0, 0, 0, 0, 0)},
            '{CMD_READ,   8'hFF,   3'd7, 5'd20, 1'b1, want_word(8'h20, 0, 0, 0, 0, 0, 0)},
            '{CMD_READ,   8'h00,   3'd7, 5'd31, 1'b1, want_word(8'h20, 0, 0, 0, 0, 0, 0)},
            '{CMD_READ,   8'h00,   3'd0, 5'd21, 1'b1, want_word(8'h20, 0, 0, 0, 0, 0, 0)},
            '{CMD_PUT,    8'h41,   3'd0, 5'd0,  1'b1, want_word(0, 1, 0, 0, 0, 0, 1)},
            '{CMD_PUT,    8'hFF,   3'd7, 5'd31, 1'b1, want_word(0, 1, 0, 1, 0, 0, 2)},
            '{CMD_PUT,    8'h00,   3'd0, 5'd0,  1'b1, want_word(0, 1, 0, 2, 0, 0, 3)},
            '{CMD_PUT,    CODE_CR, 3'd0, 5'd0,  1'b1, want_word(0, 0, 0, 0, 0, 0, 3)},
            '{CMD_UNUSED, 8'hFF,   3'd7, 5'd31, 1'b1, want_word(0, 0, 0, 0, 0, 0, 3)},
            '{CMD_READ,   8'h00,   3'd0, 5'd1,  1'b1, want_word(8'hFF, 0, 0, 0, 0, 0, 3)},
            '{CMD_READ,   8'h00,   3'd0, 5'd2,  1'b1, want_word(8'h00, 0, 0, 0, 0, 0, 3)},
            '{CMD_PUT,    CODE_LF, 3'd0, 5'd0,  1'b1, want_word(0, 0, 0, 0, 0, 1, 0)},
            '{CMD_PUT,    8'hAA,   3'd5, 5'd9,  1'b0, '0},
            '{CMD_CLEAR,  8'hFF,   3'd7, 5'd31, 1'b1, want_word(0, 0, 0, 0, 0, 0, 0)},
            '{CMD_READ,   8'h00,   3'd0, 5'd0,  1'b1, want_word(8'h20, 0, 0, 0, 0, 0, 0)},
            '{CMD_PUT,    CODE_LF, 3'd0, 5'd0,  1'b0, '0},
            '{CMD_PUT,    CODE_LF, 3'd0, 5'd0,  1'b0, '0},
            '{CMD_PUT,    CODE_LF, 3'd0, 5'd0,  1'b0, '0},
            '{CMD_PUT,    CODE_LF, 3'd0, 5'd0,  1'b0, '0},
            '{CMD_PUT,    CODE_LF, 3'd0, 5'd0,  1'b0, '0},
            '{CMD_PUT,    CODE_LF, 3'd0, 5'd0,  1'b0, '0},
            '{CMD_PUT,    CODE_LF, 3'd0, 5'd0,  1'b0, '0},
            '{CMD_PUT,    8'h5A,   3'd0, 5'd0,  1'b0, '0},
            '{CMD_PUT,    CODE_LF, 3'd0, 5'd0,  1'b1, want_word(0, 0, 0, 0, 1, 7, 0)},
            '{CMD_READ,   8'h00,   3'd6, 5'd0,  1'b0, '0},
            '{CMD_READ,   8'h00,   3'd7, 5'd0,  1'b1, want_word(8'h20, 0, 0, 0, 0, 7, 0)}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < $size(script); i++)
        begin
            send_word(script[i].op, script[i].code, script[i].row, script[i].col,
                      script[i].typed, script[i].want);
        end

        // Random text: mostly printable bursts with line breaks and cell reads,
        // some raw bytes, rare clears and ignored words.
        useful = 0;
        while (useful < RANDOM_WORDS)
        begin
            steady = (useful >= 300 && useful < 500);
            if (useful == 700 && !hold_request)
            begin
                hold_request = 1'b1;
            end
            pick = $urandom_range(0, 999);
            code = 8'($urandom_range(0, 255));
            row = 3'($urandom_range(0, 7));
            col = 5'($urandom_range(0, 31));
            if (pick < 5)
            begin
                op = CMD_CLEAR;
            end
            else if (pick < 15)
            begin
                op = CMD_UNUSED;
            end
            else if (pick < 315)
            begin
                op = CMD_READ;
                if ($urandom_range(0, 9) != 0)
                begin
                    col = 5'($urandom_range(0, COLS - 1));
                end
            end
            else
            begin
                op = CMD_PUT;
                kind = $urandom_range(0, 99);
                if (kind < 8)
                begin
                    code = CODE_LF;
                end
                else if (kind < 12)
                begin
                    code = CODE_CR;
                end
                else if (kind >= 22)
                begin
                    code = 8'($urandom_range(8'h20, 8'h7E));
                end
            end
            send_word(op, code, row, col, 1'b0, '0);
            if (op != CMD_UNUSED && !(op == CMD_PUT && code == CODE_CR))
            begin
                useful++;
            end
        end
        steady = 1'b0;
        cmd_ch.valid <= 1'b0;

        // Wait for every result, then a few more cycles for stray words.
        while (offer_notes.size() != 0 || pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fault_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
